### rtl/kuec_pkg.sv
// shared types, field widths and codes of the k-mer extension classifier
`timescale 1ns / 1ps

package kuec_pkg;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int REG_W  = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MER_LENGTH   = 2'd0;
    localparam logic [1:0] REG_MIN_COVERAGE = 2'd1;
    localparam logic [1:0] REG_MIN_CONTINUE = 2'd2;
    localparam logic [1:0] REG_BOTH_STRANDS = 2'd3;

    // register reset values
    localparam logic [5:0]  MER_LENGTH_RST   = 6'd31;
    localparam logic [31:0] MIN_COVERAGE_RST = 32'd2;
    localparam logic [31:0] MIN_CONTINUE_RST = 32'd3;
    localparam logic        BOTH_STRANDS_RST = 1'b1;

    // stream widths
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 200;

    // action codes (input tuser)
    localparam logic ACTION_QUERY  = 1'b0;
    localparam logic ACTION_REPORT = 1'b1;

    // result kind codes (output tuser)
    localparam logic KIND_ANSWER  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // verdict codes
    localparam logic [2:0] VERDICT_UNIQUE     = 3'd0;
    localparam logic [2:0] VERDICT_BRANCH     = 3'd1;
    localparam logic [2:0] VERDICT_AMBIGUOUS  = 3'd2;
    localparam logic [2:0] VERDICT_UNIQUE_LOW = 3'd3;
    localparam logic [2:0] VERDICT_DRY        = 3'd4;

    // index of the last report of a round, and counter saturation value
    localparam logic [1:0] LAST_REPORT = 2'd3;
    localparam logic [2:0] COUNT_MAX   = 3'd7;

    // one remembered neighbour
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] canon;
        logic [VAL_W-1:0] id;
        logic [VAL_W-1:0] count;
    } kuec_entry_t;

    // saturating counter step
    function automatic logic [2:0] sat_inc(input logic [2:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 3'd1;
    endfunction

endpackage

### rtl/kmer_unique_extension_classifier.sv
// k-mer unique extension classifier: neighbour keys and per-round verdicts
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+---------------------------------------
//   cfg     | in  | psel/penable/pready| four 32-bit registers at 0x0..0xC
//   s       | in  | s_tvalid/s_tready  | query or report, tuser = action
//   m       | out | m_tvalid/m_tready  | answer or verdict, tuser = result_kind
//
// one word per cycle while s_tready is high: each accepted word is done in one
// pass from the accept edge into the output register, or into the skid entry if it stalls
// reports that are not the fourth of a round give no result word
// a two-entry output (register plus skid) keeps s_tready high while one word
// waits in a stalled output; s_tready drops only when both entries hold words
// reset clears counters, handshake state and registers to their defaults
`timescale 1ns / 1ps

module kmer_unique_extension_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kuec_pkg::ADDR_W-1:0]         paddr,
    input  logic [kuec_pkg::REG_W-1:0]          pwdata,
    output logic [kuec_pkg::REG_W-1:0]          prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_key[63:0], direction[64], base[66:65], lookup_found[67],
    // lookup_count[99:68], lookup_id[131:100], zero[135:132]
    input  logic [kuec_pkg::IN_DATA_W-1:0]      s_tdata,
    // action[0]
    input  logic                                s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_key[63:0], result_canonical_key[127:64], verdict[130:128],
    // result_id[162:131], result_count[194:163], zero[199:195]
    output logic [kuec_pkg::OUT_DATA_W-1:0]     m_tdata,
    // result_kind[0]
    output logic                                m_tuser
);

    import kuec_pkg::*;

    // configuration registers
    logic [5:0]       mer_length_reg;
    logic [VAL_W-1:0] min_coverage_reg;
    logic [VAL_W-1:0] min_continue_reg;
    logic             both_strands_reg;

    // round state
    logic [KEY_W-1:0] tried_keys_reg  [4];
    logic [KEY_W-1:0] tried_canon_reg [4];
    logic [2:0]       strong_count_reg, strong_count_next;
    logic [2:0]       present_count_reg, present_count_next;
    logic [2:0]       weak_count_reg, weak_count_next;
    logic [1:0]       report_count_reg;
    kuec_entry_t      chosen_entry_reg, chosen_entry_next;
    kuec_entry_t      weak_entry_reg, weak_entry_next;

    // output buffer
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_user_reg, out_user_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [OUT_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic                  skid_user_reg, skid_user_next;

    // input fields
    logic             action;
    logic [KEY_W-1:0] in_key;
    logic             direction;
    logic [1:0]       base;
    logic             lookup_found;
    logic [VAL_W-1:0] lookup_count;
    logic [VAL_W-1:0] lookup_id;

    logic             s_fire;
    logic             m_fire;
    logic             cfg_write;

    logic [5:0]       k_eff;
    logic [6:0]       two_k;
    logic [KEY_W-1:0] key_mask;
    logic [KEY_W-1:0] nb_key;
    logic [KEY_W-1:0] rc_full;
    logic [KEY_W-1:0] rc_key;
    logic [KEY_W-1:0] canon_key;

    kuec_entry_t      report_entry;
    kuec_entry_t      verdict_entry;
    logic [2:0]       verdict;
    logic             present_hit;
    logic             strong_hit;
    logic             weak_hit;
    logic             round_end;
    logic             have_result;
    logic [OUT_DATA_W-1:0] result_data;
    logic             result_user;

    assign action       = s_tuser;
    assign in_key       = s_tdata[63:0];
    assign direction    = s_tdata[64];
    assign base         = s_tdata[66:65];
    assign lookup_found = s_tdata[67];
    assign lookup_count = s_tdata[99:68];
    assign lookup_id    = s_tdata[131:100];

    assign s_tready  = !skid_valid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mer_length_reg   <= MER_LENGTH_RST;
            min_coverage_reg <= MIN_COVERAGE_RST;
            min_continue_reg <= MIN_CONTINUE_RST;
            both_strands_reg <= BOTH_STRANDS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MER_LENGTH:   mer_length_reg   <= pwdata[5:0];
                REG_MIN_COVERAGE: min_coverage_reg <= pwdata;
                REG_MIN_CONTINUE: min_continue_reg <= pwdata;
                REG_BOTH_STRANDS: both_strands_reg <= pwdata[0];
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MER_LENGTH:   prdata = {26'd0, mer_length_reg};
            REG_MIN_COVERAGE: prdata = min_coverage_reg;
            REG_MIN_CONTINUE: prdata = min_continue_reg;
            REG_BOTH_STRANDS: prdata = {31'd0, both_strands_reg};
        endcase
    end

    // effective length and key mask, zero acts as one base, above 32 as 32
    always_comb
    begin
        if (mer_length_reg == 6'd0)
            k_eff = 6'd1;
        else if (mer_length_reg > 6'd32)
            k_eff = 6'd32;
        else
            k_eff = mer_length_reg;
    end

    assign two_k    = {k_eff, 1'b0};
    assign key_mask = {KEY_W{1'b1}} >> (7'd64 - two_k);

    // neighbour key: append or prepend one base
    always_comb
    begin
        if (direction)
            nb_key = ((in_key >> 2) & (key_mask >> 2))
                   | ({62'd0, base} << (two_k - 7'd2));
        else
            nb_key = ((in_key << 2) & key_mask & ~64'd3) | {62'd0, base};
    end

    // reverse complement over all 32 bases, then align to the mer length
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            rc_full[2*(31-i) +: 2] = ~nb_key[2*i +: 2];
        end
    end

    assign rc_key    = rc_full >> (7'd64 - two_k);
    assign canon_key = (both_strands_reg && (rc_key < nb_key)) ? rc_key : nb_key;

    // report classification
    assign report_entry.key   = tried_keys_reg[base];
    assign report_entry.canon = tried_canon_reg[base];
    assign report_entry.id    = lookup_id;
    assign report_entry.count = lookup_count;

    assign present_hit = lookup_found && (lookup_count >= min_coverage_reg);
    assign strong_hit  = present_hit && (lookup_count >= min_continue_reg);
    assign weak_hit    = lookup_found && !(lookup_count >= min_coverage_reg);

    assign present_count_next = present_hit ? sat_inc(present_count_reg) : present_count_reg;
    assign strong_count_next  = strong_hit ? sat_inc(strong_count_reg) : strong_count_reg;
    assign weak_count_next    = weak_hit ? sat_inc(weak_count_reg) : weak_count_reg;

    assign chosen_entry_next = (strong_hit && strong_count_reg == 3'd0)
                             ? report_entry : chosen_entry_reg;
    assign weak_entry_next   = (weak_hit && weak_count_reg == 3'd0)
                             ? report_entry : weak_entry_reg;

    assign round_end = (report_count_reg == LAST_REPORT);

    // verdict from the counts including this report
    always_comb
    begin
        verdict_entry = '0;
        priority if (strong_count_next > 3'd1)
        begin
            verdict = VERDICT_BRANCH;
        end
        else if (present_count_next > 3'd1)
        begin
            verdict = VERDICT_AMBIGUOUS;
        end
        else if (strong_count_next == 3'd1)
        begin
            verdict       = VERDICT_UNIQUE;
            verdict_entry = chosen_entry_next;
        end
        else if (weak_count_next == 3'd1 && present_count_next == 3'd0)
        begin
            verdict       = VERDICT_UNIQUE_LOW;
            verdict_entry = weak_entry_next;
        end
        else
        begin
            verdict = VERDICT_DRY;
        end
    end

    // result word
    always_comb
    begin
        if (action == ACTION_QUERY)
        begin
            result_user = KIND_ANSWER;
            result_data = {5'd0, 32'd0, 32'd0, VERDICT_UNIQUE, canon_key, nb_key};
        end
        else
        begin
            result_user = KIND_VERDICT;
            result_data = {5'd0, verdict_entry.count, verdict_entry.id, verdict,
                           verdict_entry.canon, verdict_entry.key};
        end
    end

    assign have_result = s_fire && ((action == ACTION_QUERY) || round_end);

    // tried keys, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire && action == ACTION_QUERY)
        begin
            tried_keys_reg[base]  <= nb_key;
            tried_canon_reg[base] <= canon_key;
        end
    end

    // remembered neighbours, read only while their counts say they are set
    always_ff @(posedge clk)
    begin
        if (s_fire && action == ACTION_REPORT)
        begin
            chosen_entry_reg <= chosen_entry_next;
            weak_entry_reg   <= weak_entry_next;
        end
    end

    // round counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strong_count_reg  <= 3'd0;
            present_count_reg <= 3'd0;
            weak_count_reg    <= 3'd0;
            report_count_reg  <= 2'd0;
        end
        else if (s_fire && action == ACTION_REPORT)
        begin
            report_count_reg <= report_count_reg + 2'd1;
            if (round_end)
            begin
                strong_count_reg  <= 3'd0;
                present_count_reg <= 3'd0;
                weak_count_reg    <= 3'd0;
            end
            else
            begin
                strong_count_reg  <= strong_count_next;
                present_count_reg <= present_count_next;
                weak_count_reg    <= weak_count_next;
            end
        end
    end

    // output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;
        if (skid_valid_reg)
        begin
            if (m_fire)
            begin
                out_data_next   = skid_data_reg;
                out_user_next   = skid_user_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (have_result)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result_data;
                out_user_next  = result_user;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result_data;
                skid_user_next  = result_user;
            end
        end
        else if (m_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

endmodule

### tb/kmer_unique_extension_classifier_test.sv
// self-checking stream testbench for the k-mer unique extension classifier
`timescale 1ns / 1ps

module kmer_unique_extension_classifier_test;
    import kuec_pkg::*;

    localparam int BASES_PER_ROUND = 4;
    localparam int QUIET_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int SEGMENT_ITEMS   = 200;
    localparam int REPORT_LIMIT    = 10;

    // one input word and one result word, unpacked from the bus
    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
        logic             dir;
        logic [1:0]       base;
        logic             found;
        logic [VAL_W-1:0] count;
        logic [VAL_W-1:0] id;
    } ext_item_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] canon;
        logic [2:0]       verdict;
        logic [VAL_W-1:0] id;
        logic [VAL_W-1:0] count;
    } ext_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [REG_W-1:0]      pwdata = '0;
    logic [REG_W-1:0]      prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    kmer_unique_extension_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // stimulus and expectation stores
    ext_item_t   pending_words[$];
    ext_result_t expected_results[$];
    int          words_left = 0;
    int          items_made = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          word_taken = 1'b0;

    // register copies seen by the classifier model
    logic [5:0]       cfg_mer_length = MER_LENGTH_RST;
    logic [VAL_W-1:0] cfg_min_cov    = MIN_COVERAGE_RST;
    logic [VAL_W-1:0] cfg_cont_cov   = MIN_CONTINUE_RST;
    logic             cfg_both       = BOTH_STRANDS_RST;

    // classifier model state
    logic [KEY_W-1:0] tried_key[BASES_PER_ROUND];
    logic [KEY_W-1:0] tried_canon[BASES_PER_ROUND];
    int               strong_seen = 0;
    int               present_seen = 0;
    int               weak_seen = 0;
    int               reports_seen = 0;
    kuec_entry_t      chosen_nbr = '0;
    kuec_entry_t      weak_nbr = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reverse complement of a k-base key
    function automatic logic [KEY_W-1:0] rev_complement(input logic [KEY_W-1:0] x,
                                                        input int k);
        logic [KEY_W-1:0] r;
        int               i;
        r = '0;
        for (i = 0; i < k; i++)
        begin
            r = {r[KEY_W-3:0], 2'd3 - x[1:0]};
            x = x >> 2;
        end
        return r;
    endfunction

    // one word through the classifier; returns 1 when it yields a result word
    function automatic bit classify_step(input ext_item_t w, output ext_result_t r);
        int               k;
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] nkey;
        logic [KEY_W-1:0] ckey;
        logic [KEY_W-1:0] rc;
        kuec_entry_t      e;
        r = '0;
        k = int'(cfg_mer_length);
        if (k == 0) k = 1;
        if (k > 32) k = 32;
        mask = (k >= 32) ? '1 : (64'd1 << (2 * k)) - 64'd1;

        // query: neighbour key and its lookup key
        if (w.action == ACTION_QUERY)
        begin
            if (w.dir == 1'b0)
                nkey = ((w.key << 2) & (mask - 64'd3)) | 64'(w.base);
            else
                nkey = ((w.key >> 2) & (mask >> 2)) | (64'(w.base) << (2 * k - 2));
            ckey = nkey;
            if (cfg_both)
            begin
                rc = rev_complement(nkey, k);
                if (rc < ckey) ckey = rc;
            end
            tried_key[w.base]   = nkey;
            tried_canon[w.base] = ckey;
            r.kind  = KIND_ANSWER;
            r.key   = nkey;
            r.canon = ckey;
            return 1'b1;
        end

        // report: classify the neighbour
        if (w.found)
        begin
            e.key   = tried_key[w.base];
            e.canon = tried_canon[w.base];
            e.id    = w.id;
            e.count = w.count;
            if (w.count >= cfg_min_cov)
            begin
                if (present_seen < 7) present_seen++;
                if (w.count >= cfg_cont_cov)
                begin
                    if (strong_seen < 7) strong_seen++;
                    if (strong_seen == 1) chosen_nbr = e;
                end
            end
            else
            begin
                if (weak_seen < 7) weak_seen++;
                if (weak_seen == 1) weak_nbr = e;
            end
        end
        reports_seen++;
        if (reports_seen < BASES_PER_ROUND) return 1'b0;

        // fourth report closes the round
        e = '0;
        r.kind = KIND_VERDICT;
        if (strong_seen > 1)
        begin
            r.verdict = VERDICT_BRANCH;
        end
        else if (present_seen > 1)
        begin
            r.verdict = VERDICT_AMBIGUOUS;
        end
        else if (strong_seen == 1)
        begin
            r.verdict = VERDICT_UNIQUE;
            e = chosen_nbr;
        end
        else if (weak_seen == 1 && present_seen == 0)
        begin
            r.verdict = VERDICT_UNIQUE_LOW;
            e = weak_nbr;
        end
        else
        begin
            r.verdict = VERDICT_DRY;
        end
        r.key   = e.key;
        r.canon = e.canon;
        r.id    = e.id;
        r.count = e.count;
        reports_seen = 0;
        strong_seen  = 0;
        present_seen = 0;
        weak_seen    = 0;
        chosen_nbr   = '0;
        weak_nbr     = '0;
        return 1'b1;
    endfunction

    // driver: present queued words and toggle the output ready
    always @(negedge clk)
    begin : driver
        ext_item_t w;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (!s_tvalid || word_taken)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    w = pending_words.pop_front();
                    s_tdata  <= {4'b0, w.id, w.count, w.found, w.base, w.dir, w.key};
                    s_tuser  <= w.action;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check result words, predict from accepted input words
    always @(posedge clk)
    begin : monitor
        ext_result_t got;
        ext_result_t want;
        ext_result_t predicted;
        ext_item_t   w;
        bit          has_result;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind    = m_tuser;
                got.key     = m_tdata[63:0];
                got.canon   = m_tdata[127:64];
                got.verdict = m_tdata[130:128];
                got.id      = m_tdata[162:131];
                got.count   = m_tdata[194:163];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected word: kind %0d key %h verdict %0d",
                                 got.kind, got.key, got.verdict);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.key !== want.key ||
                        got.canon !== want.canon || got.verdict !== want.verdict ||
                        got.id !== want.id || got.count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display(
                                "mismatch exp: kind %0d key %h canon %h verdict %0d id %h cnt %h",
                                want.kind, want.key, want.canon, want.verdict,
                                want.id, want.count);
                            $display(
                                "         got: kind %0d key %h canon %h verdict %0d id %h cnt %h",
                                got.kind, got.key, got.canon, got.verdict,
                                got.id, got.count);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                w.action = s_tuser;
                w.key    = s_tdata[63:0];
                w.dir    = s_tdata[64];
                w.base   = s_tdata[66:65];
                w.found  = s_tdata[67];
                w.count  = s_tdata[99:68];
                w.id     = s_tdata[131:100];
                has_result = classify_step(w, predicted);
                if (has_result) expected_results = {expected_results, predicted};
                words_left--;
            end
            word_taken = s_tvalid && s_tready;

            // watchdog on handshake activity
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // queue one input word
    task automatic add_item(input ext_item_t w);
        pending_words = {pending_words, w};
        words_left++;
        items_made++;
    endtask

    task automatic add_query(input logic [KEY_W-1:0] key, input logic dir,
                             input logic [1:0] base);
        ext_item_t w;
        w = '0;
        w.action = ACTION_QUERY;
        w.key    = key;
        w.dir    = dir;
        w.base   = base;
        add_item(w);
    endtask

    task automatic add_report(input logic [1:0] base, input logic found,
                              input logic [VAL_W-1:0] count, input logic [VAL_W-1:0] id);
        ext_item_t w;
        w = '0;
        w.action = ACTION_REPORT;
        w.base   = base;
        w.found  = found;
        w.count  = count;
        w.id     = id;
        add_item(w);
    endtask

    // keys lean random with some all-zero and all-one
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // counts cluster around the two thresholds
    function automatic logic [VAL_W-1:0] pick_count();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return cfg_min_cov;
            3:       return cfg_min_cov - 32'd1;
            4:       return cfg_cont_cov;
            5:       return cfg_cont_cov - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // well-formed round of queries then reports, sometimes broken
    task automatic add_round();
        logic [KEY_W-1:0] key;
        logic             dir;
        logic [1:0]       base;
        int               nq;
        int               nr;
        int               first;
        int               mid;
        int               i;
        key   = pick_key();
        dir   = 1'($urandom_range(1));
        nq    = ($urandom_range(9) == 0) ? int'($urandom_range(3)) : BASES_PER_ROUND;
        nr    = ($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : BASES_PER_ROUND;
        first = int'($urandom_range(3));
        mid   = int'($urandom_range(nr - 1));
        for (i = 0; i < nq; i++)
            add_query(key, dir, 2'(first + i));
        for (i = 0; i < nr; i++)
        begin
            if (i == mid && $urandom_range(4) == 0)
                add_query(pick_key(), 1'($urandom_range(1)), 2'($urandom_range(3)));
            base = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : 2'(first + i);
            add_report(base, $urandom_range(3) != 0, pick_count(), $urandom);
        end
    endtask

    // random words: mostly rounds, some noise
    task automatic add_segment(input int n);
        int        start;
        ext_item_t w;
        start = items_made;
        while (items_made - start < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                w.action = 1'($urandom_range(1));
                w.key    = pick_key();
                w.dir    = 1'($urandom_range(1));
                w.base   = 2'($urandom_range(3));
                w.found  = 1'($urandom_range(1));
                w.count  = pick_count();
                w.id     = $urandom;
                add_item(w);
            end
            else
            begin
                add_round();
            end
        end
    endtask

    // wait until all words are in and all results out, then let the block go quiet
    task automatic settle();
        while (words_left != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write: setup then access
    task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MER_LENGTH:   cfg_mer_length = value[5:0];
            REG_MIN_COVERAGE: cfg_min_cov    = value;
            REG_MIN_CONTINUE: cfg_cont_cov   = value;
            REG_BOTH_STRANDS: cfg_both       = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [5:0] mer, input logic [VAL_W-1:0] min_cov,
                              input logic [VAL_W-1:0] cont_cov, input logic both);
        write_reg(REG_MER_LENGTH, 32'(mer));
        write_reg(REG_MIN_COVERAGE, min_cov);
        write_reg(REG_MIN_CONTINUE, cont_cov);
        write_reg(REG_BOTH_STRANDS, 32'(both));
    endtask

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 12;
        rx_idle_pct = 75;

        // directed: reset settings, every verdict, extreme keys and counts
        add_query('1, 1'b0, 2'd0);
        add_query('1, 1'b0, 2'd1);
        add_query('1, 1'b0, 2'd2);
        add_query('1, 1'b0, 2'd3);
        // unique, with a query in the middle of the round
        add_report(2'd0, 1'b1, '1, '1);
        add_report(2'd1, 1'b0, 32'd0, 32'd0);
        add_query('0, 1'b1, 2'd3);
        add_report(2'd2, 1'b0, 32'd9, 32'd1);
        add_report(2'd3, 1'b1, 32'd1, 32'd2);
        // branch, one base reported twice
        add_report(2'd1, 1'b1, 32'd3, 32'd3);
        add_report(2'd1, 1'b1, 32'd7, 32'd4);
        add_report(2'd2, 1'b0, 32'd0, 32'd0);
        add_report(2'd0, 1'b0, 32'd0, 32'd0);
        // ambiguous
        add_report(2'd0, 1'b1, 32'd2, 32'd5);
        add_report(2'd3, 1'b1, 32'd3, 32'd6);
        add_report(2'd1, 1'b0, 32'd0, 32'd0);
        add_report(2'd2, 1'b0, 32'd0, 32'd0);
        // unique low
        add_report(2'd0, 1'b0, '1, 32'd0);
        add_report(2'd2, 1'b1, 32'd1, 32'd8);
        add_report(2'd1, 1'b0, '1, 32'd0);
        add_report(2'd3, 1'b0, '1, 32'd0);
        // dry: two weak neighbours
        add_report(2'd0, 1'b1, 32'd0, 32'd9);
        add_report(2'd1, 1'b1, 32'd1, 32'd10);
        add_report(2'd2, 1'b0, 32'd0, 32'd0);
        add_report(2'd3, 1'b0, 32'd0, 32'd0);
        settle();

        // random segments over several settings
        set_config(6'd1, 32'd0, 32'd0, 1'b1);
        add_segment(SEGMENT_ITEMS);
        settle();
        set_config(6'd32, '1, '1, 1'b0);
        add_segment(SEGMENT_ITEMS);
        settle();

        tx_idle_pct = 75;
        rx_idle_pct = 12;
        set_config(6'd0, 32'd1, 32'd4, 1'b1);
        add_segment(SEGMENT_ITEMS);
        settle();
        set_config(6'd63, 32'd2, 32'd3, 1'b1);
        add_segment(SEGMENT_ITEMS);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(6'd12, 32'd5, 32'd2, 1'b0);
        add_segment(SEGMENT_ITEMS);
        settle();
        set_config(6'd31, 32'd2, 32'd3, 1'b1);
        add_segment(SEGMENT_ITEMS);
        settle();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
